// File: hw/rtl/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg
// Shared types, constants and sign-magnitude helpers for the least-squares
// polynomial fit unit.
// ----------------------------------------------------------------------------
package plsf_pkg;

	localparam int MAG_W      = 127;
	localparam int LIMB_W     = 32;
	localparam int LIMBS      = 4;
	localparam int DIV_STEPS  = 160;
	localparam int SUM_W      = 64;
	localparam int TIME_W     = 8;
	localparam int VALUE_W    = 24;
	localparam int COEF_W     = 64;
	localparam int POWER_W    = 2;
	localparam int DEGREE_W   = 2;
	localparam int THR_W      = 33;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 33;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_DEGREE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESHOLD = 1'b1;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// sign-magnitude Q95.32
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} wide_t;

	typedef struct packed {
		logic               strobe;
		logic [POWER_W-1:0] power;
		logic [COEF_W-1:0]  value;
		logic               last;
	} coef_t;

	function automatic wide_t w_add(wide_t a, wide_t b);
		logic [MAG_W:0] s;
		wide_t          r;
		if (a.neg == b.neg) begin
			s = {1'b0, a.mag} + {1'b0, b.mag};
			if (s[MAG_W]) begin
				r = '{neg: a.neg, mag: MAG_MAX};
			end else begin
				r = '{neg: a.neg && (|s[MAG_W-1:0]), mag: s[MAG_W-1:0]};
			end
		end else if (a.mag == b.mag) begin
			r = '0;
		end else if (a.mag > b.mag) begin
			r = '{neg: a.neg, mag: a.mag - b.mag};
		end else begin
			r = '{neg: b.neg, mag: b.mag - a.mag};
		end
		return r;
	endfunction

	function automatic wide_t w_sub(wide_t a, wide_t b);
		wide_t nb;
		nb     = b;
		nb.neg = b.neg ^ (|b.mag);
		return w_add(a, nb);
	endfunction

	// unit result: saturate or take magnitude, drop the sign of zero
	function automatic wide_t w_make(logic neg, logic sat, logic [MAG_W-1:0] mag);
		wide_t r;
		if (sat) begin
			r = '{neg: neg, mag: MAG_MAX};
		end else begin
			r = '{neg: neg && (|mag), mag: mag};
		end
		return r;
	endfunction

	function automatic wide_t w_from_int(logic [SUM_W-1:0] s);
		return '{neg: 1'b0, mag: {31'b0, s, 32'b0}};
	endfunction

	function automatic wide_t w_from_q12(logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] m;
		m = v[SUM_W-1] ? (~v + 64'd1) : v;
		return '{neg: v[SUM_W-1] && (|m), mag: {43'b0, m, 20'b0}};
	endfunction

	function automatic logic [COEF_W-1:0] w_to_q32(wide_t a);
		logic [COEF_W-1:0] m;
		logic [COEF_W-1:0] r;
		m = a.mag[COEF_W-1:0];
		if (|a.mag[MAG_W-1:COEF_W]) begin
			r = a.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else if (!a.neg) begin
			r = m[COEF_W-1] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		end else if (m > 64'h8000_0000_0000_0000) begin
			r = 64'h8000_0000_0000_0000;
		end else begin
			r = ~m + 64'd1;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/plsf_accum.sv
// ----------------------------------------------------------------------------
// plsf_accum
// Power-sum accumulator: steps one power of time per cycle through a shared
// multiplier, adding t^p and t^p*y into the sums.
// ----------------------------------------------------------------------------
module plsf_accum #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_DEGREE  = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [plsf_pkg::TIME_W-1:0]         t,
	input  logic signed [plsf_pkg::VALUE_W-1:0] y,
	input  logic                                clear,
	output logic                                busy,
	output logic                                done,
	output logic [plsf_pkg::SUM_W-1:0]          tps [2*MAX_DEGREE+1],
	output logic [plsf_pkg::SUM_W-1:0]          wvs [MAX_DEGREE+1]
);
	import plsf_pkg::*;

	localparam int NPOW = 2 * MAX_DEGREE + 1;
	localparam int NCOEF = MAX_DEGREE + 1;
	localparam int SW = $clog2(NPOW);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int PW_W = TIME_W * (NPOW - 1);
	localparam int LO_W = TIME_W * MAX_DEGREE;

	logic [TIME_W-1:0]               t_q;
	logic signed [VALUE_W-1:0]       y_q;
	logic [PW_W-1:0]                 pw_q;
	logic [SW-1:0]                   step_q;
	logic                            busy_q;
	logic                            en_q;
	logic [CNT_W-1:0]                cnt_q;
	logic signed [LO_W+VALUE_W:0]    wprod_full;
	logic signed [SUM_W-1:0]         wprod;
	logic [PW_W+TIME_W-1:0]          pw_next;

	assign busy = busy_q;
	assign done = busy_q && (step_q == SW'(NPOW - 1));
	assign wprod_full = $signed({1'b0, pw_q[LO_W-1:0]}) * y_q;
	assign wprod = SUM_W'(wprod_full);
	assign pw_next = pw_q * t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			en_q   <= 1'b0;
			step_q <= '0;
			cnt_q  <= '0;
			t_q    <= '0;
			y_q    <= '0;
			pw_q   <= '0;
			for (int e = 0; e < NPOW; e++) tps[e] <= '0;
			for (int e = 0; e < NCOEF; e++) wvs[e] <= '0;
		end else if (clear) begin
			cnt_q <= '0;
			for (int e = 0; e < NPOW; e++) tps[e] <= '0;
			for (int e = 0; e < NCOEF; e++) wvs[e] <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			en_q   <= (cnt_q < CNT_W'(MAX_SAMPLES));
			step_q <= '0;
			t_q    <= t;
			y_q    <= y;
			pw_q   <= PW_W'(1);
			if (cnt_q < CNT_W'(MAX_SAMPLES)) cnt_q <= cnt_q + 1'b1;
		end else if (busy_q) begin
			for (int e = 0; e < NPOW; e++) begin
				if (en_q && step_q == SW'(e)) tps[e] <= tps[e] + SUM_W'(pw_q);
			end
			for (int e = 0; e < NCOEF; e++) begin
				if (en_q && step_q == SW'(e)) wvs[e] <= wvs[e] + wprod;
			end
			pw_q <= pw_next[PW_W-1:0];
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/plsf_mul.sv
// ----------------------------------------------------------------------------
// plsf_mul
// Magnitude multiplier: one 32x32 partial product per cycle, result scaled
// down by 2^32 with saturation flag.
// ----------------------------------------------------------------------------
module plsf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [plsf_pkg::MAG_W-1:0] a,
	input  logic [plsf_pkg::MAG_W-1:0] b,
	output logic                       done,
	output logic                       sat,
	output logic [plsf_pkg::MAG_W-1:0] mag
);
	import plsf_pkg::*;

	localparam int OP_W = LIMB_W * LIMBS;
	localparam int ACC_W = 2 * MAG_W;

	logic [OP_W-1:0]        a_q, b_q;
	logic [ACC_W-1:0]       acc_q;
	logic [3:0]             cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [1:0]             ia, ib;
	logic [2*LIMB_W-1:0]    pp;
	logic [2:0]             pos;

	assign ia  = cnt_q[3:2];
	assign ib  = cnt_q[1:0];
	assign pp  = a_q[ia*LIMB_W +: LIMB_W] * b_q[ib*LIMB_W +: LIMB_W];
	assign pos = {1'b0, ia} + {1'b0, ib};

	assign done = done_q;
	assign sat  = |acc_q[ACC_W-1:MAG_W+LIMB_W];
	assign mag  = acc_q[MAG_W+LIMB_W-1:LIMB_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 4'hF);
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				a_q   <= {1'b0, a};
				b_q   <= {1'b0, b};
				acc_q <= '0;
			end else if (run_q) begin
				acc_q <= acc_q + (ACC_W'(pp) << {pos, 5'b0});
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'hF) run_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/plsf_div.sv
// ----------------------------------------------------------------------------
// plsf_div
// Restoring magnitude divider: (a << 32) / b, one quotient bit per cycle,
// with saturation flag.
// ----------------------------------------------------------------------------
module plsf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [plsf_pkg::MAG_W-1:0] a,
	input  logic [plsf_pkg::MAG_W-1:0] b,
	output logic                       done,
	output logic                       sat,
	output logic [plsf_pkg::MAG_W-1:0] mag
);
	import plsf_pkg::*;

	localparam int NUM_W = MAG_W + LIMB_W + 1;
	localparam int CW = $clog2(DIV_STEPS);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] b_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [MAG_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[MAG_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, b_q};

	assign done = done_q;
	assign sat  = |quo_q[NUM_W-1:MAG_W];
	assign mag  = quo_q[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			b_q    <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(DIV_STEPS - 1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				num_q <= {1'b0, a, {LIMB_W{1'b0}}};
				quo_q <= '0;
				rem_q <= '0;
				b_q   <= b;
			end else if (run_q) begin
				rem_q <= ge ? (rem_sh - {1'b0, b_q}) : rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], ge};
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) run_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/plsf_solver.sv
// ----------------------------------------------------------------------------
// plsf_solver
// Normal-equation solver: loads the matrix into a small memory, then runs
// elimination and back substitution through the shared multiplier and divider.
// ----------------------------------------------------------------------------
module plsf_solver #(
	parameter int MAX_DEGREE = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [plsf_pkg::DEGREE_W-1:0]   deg,
	input  logic [plsf_pkg::THR_W-1:0]      thr,
	input  logic [plsf_pkg::SUM_W-1:0]      tps [2*MAX_DEGREE+1],
	input  logic [plsf_pkg::SUM_W-1:0]      wvs [MAX_DEGREE+1],
	output logic                            busy,
	output logic                            acc_clear,
	output plsf_pkg::coef_t                 coef
);
	import plsf_pkg::*;

	localparam int NCOEF = MAX_DEGREE + 1;
	localparam int NPOW = 2 * MAX_DEGREE + 1;
	localparam int BBASE = NCOEF * NCOEF;
	localparam int DEPTH = BBASE + NCOEF;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(NCOEF + 1);
	localparam int PW = $clog2(NPOW);
	localparam int CW = $clog2(NCOEF);

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_LOAD  = 18'h00002,
		S_PRD   = 18'h00004,
		S_PCHK  = 18'h00008,
		S_DRD   = 18'h00010,
		S_DLD   = 18'h00020,
		S_DRUN  = 18'h00040,
		S_DWR   = 18'h00080,
		S_FRD   = 18'h00100,
		S_FLD   = 18'h00200,
		S_YRD   = 18'h00400,
		S_YLD   = 18'h00800,
		S_MRUN  = 18'h01000,
		S_XRD   = 18'h02000,
		S_XWR   = 18'h04000,
		S_BSROW = 18'h08000,
		S_ORD   = 18'h10000,
		S_OEMIT = 18'h20000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   m_q, i_q, j_q, k_q;
	logic            bs_q;
	wide_t           piv_q, f_q;
	logic            y_neg_q, d_neg_q;
	coef_t           coef_q;

	wide_t           mem [DEPTH];
	wide_t           rdata_q;
	logic [AW-1:0]   raddr, waddr;
	logic            we;
	wide_t           wdata;

	logic            div_go, div_done, div_sat;
	logic [MAG_W-1:0] div_mag;
	logic            mul_go, mul_done, mul_sat;
	logic [MAG_W-1:0] mul_mag;
	wide_t           quot, prod;
	logic [AW-1:0]   x_addr;
	logic            skip;
	logic [DEGREE_W-1:0] deg_c;

	function automatic logic [AW-1:0] a_addr(logic [IW-1:0] r, logic [IW-1:0] c);
		return AW'(r * NCOEF + c);
	endfunction

	function automatic logic [AW-1:0] b_addr(logic [IW-1:0] r);
		return AW'(BBASE + r);
	endfunction

	assign deg_c = (deg > DEGREE_W'(MAX_DEGREE)) ? DEGREE_W'(MAX_DEGREE) : deg;

	plsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.a      (rdata_q.mag),
		.b      (piv_q.mag),
		.done   (div_done),
		.sat    (div_sat),
		.mag    (div_mag)
	);

	plsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (f_q.mag),
		.b      (rdata_q.mag),
		.done   (mul_done),
		.sat    (mul_sat),
		.mag    (mul_mag)
	);

	assign quot   = w_make(d_neg_q ^ piv_q.neg, div_sat, div_mag);
	assign prod   = w_make(f_q.neg ^ y_neg_q, mul_sat, mul_mag);
	assign div_go = (state_q == S_DLD);
	assign mul_go = (state_q == S_YLD);
	assign skip   = (rdata_q.mag == '0) || (rdata_q.mag < MAG_W'(thr));
	assign x_addr = bs_q ? b_addr(i_q)
	              : ((j_q == m_q) ? b_addr(k_q) : a_addr(k_q, j_q));

	always_comb begin
		raddr = '0;
		waddr = '0;
		we    = 1'b0;
		wdata = '0;
		unique case (state_q)
			S_LOAD: begin
				we = 1'b1;
				if (j_q == IW'(NCOEF)) begin
					waddr = b_addr(i_q);
					wdata = w_from_q12(wvs[i_q[CW-1:0]]);
				end else begin
					waddr = a_addr(i_q, j_q);
					wdata = w_from_int(tps[PW'(i_q) + PW'(j_q)]);
				end
			end
			S_PRD: raddr = a_addr(i_q, i_q);
			S_DRD: raddr = (j_q == m_q) ? b_addr(i_q) : a_addr(i_q, j_q);
			S_DWR: begin
				we    = 1'b1;
				waddr = (j_q == m_q) ? b_addr(i_q) : a_addr(i_q, j_q);
				wdata = quot;
			end
			S_FRD: raddr = bs_q ? a_addr(i_q, j_q) : a_addr(k_q, i_q);
			S_YRD: raddr = bs_q ? b_addr(j_q)
			             : ((j_q == m_q) ? b_addr(i_q) : a_addr(i_q, j_q));
			S_XRD: raddr = x_addr;
			S_XWR: begin
				we    = 1'b1;
				waddr = x_addr;
				wdata = w_sub(rdata_q, prod);
			end
			S_ORD: raddr = b_addr(i_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			bs_q    <= 1'b0;
			piv_q   <= '0;
			f_q     <= '0;
			y_neg_q <= 1'b0;
			d_neg_q <= 1'b0;
			coef_q  <= '0;
		end else begin
			coef_q.strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						m_q     <= IW'(deg_c) + 1'b1;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (j_q == IW'(NCOEF)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q == IW'(NCOEF - 1)) begin
							i_q     <= '0;
							state_q <= S_PRD;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					piv_q <= rdata_q;
					if (!skip) begin
						j_q     <= i_q;
						state_q <= S_DRD;
					end else if (i_q + 1'b1 < m_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_PRD;
					end else begin
						state_q <= S_BSROW;
					end
				end
				S_DRD: state_q <= S_DLD;
				S_DLD: begin
					d_neg_q <= rdata_q.neg;
					state_q <= S_DRUN;
				end
				S_DRUN: if (div_done) state_q <= S_DWR;
				S_DWR: begin
					if (j_q != m_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_DRD;
					end else if (i_q + 1'b1 < m_q) begin
						k_q     <= i_q + 1'b1;
						j_q     <= i_q;
						bs_q    <= 1'b0;
						state_q <= S_FRD;
					end else begin
						state_q <= S_BSROW;
					end
				end
				S_FRD: state_q <= S_FLD;
				S_FLD: begin
					f_q     <= rdata_q;
					state_q <= S_YRD;
				end
				S_YRD: state_q <= S_YLD;
				S_YLD: begin
					y_neg_q <= rdata_q.neg;
					state_q <= S_MRUN;
				end
				S_MRUN: if (mul_done) state_q <= S_XRD;
				S_XRD: state_q <= S_XWR;
				S_XWR: begin
					if (bs_q) begin
						if (j_q + 1'b1 != m_q) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_FRD;
						end else if (i_q == '0) begin
							state_q <= S_ORD;
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_BSROW;
						end
					end else if (j_q != m_q) begin
						// keep the row factor, move to the next column
						j_q     <= j_q + 1'b1;
						state_q <= S_YRD;
					end else if (k_q + 1'b1 < m_q) begin
						k_q     <= k_q + 1'b1;
						j_q     <= i_q;
						state_q <= S_FRD;
					end else if (i_q + 1'b1 < m_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_PRD;
					end else begin
						state_q <= S_BSROW;
					end
				end
				S_BSROW: begin
					if (i_q + 1'b1 < m_q) begin
						j_q     <= i_q + 1'b1;
						bs_q    <= 1'b1;
						state_q <= S_FRD;
					end else if (i_q == '0) begin
						state_q <= S_ORD;
					end else begin
						i_q <= i_q - 1'b1;
					end
				end
				S_ORD: state_q <= S_OEMIT;
				S_OEMIT: begin
					coef_q.strobe <= 1'b1;
					coef_q.power  <= POWER_W'(i_q);
					coef_q.value  <= w_to_q32(rdata_q);
					coef_q.last   <= (i_q + 1'b1 == m_q);
					if (i_q + 1'b1 == m_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign acc_clear = (state_q == S_OEMIT) && (i_q + 1'b1 == m_q);
	assign coef      = coef_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> state_q == S_IDLE)
		else $error("solve started while solver busy");

	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_go && mul_go))
		else $error("divider and multiplier started together");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		coef_q.strobe && coef_q.last |-> state_q == S_IDLE)
		else $error("solver still running after last coefficient");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		coef_q.strobe |-> IW'(coef_q.power) < m_q)
		else $error("coefficient power beyond fit degree");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> $past(state_q) == S_DRUN)
		else $error("divider finished outside its wait state");

endmodule

// File: hw/rtl/polynomial_least_squares_fit_unit.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_unit
// Least-squares polynomial fit over a stream of (time, value) samples,
// solved from the accumulated normal equations.
//
//   channel  | signals                                        | dir
//   ---------+------------------------------------------------+-----
//   sample   | start, busy, sample_time/value, final_sample   | in; busy out
//   coeff    | coeff_strobe, coeff_power/value/last           | out
//   config   | cfg_we, cfg_index, cfg_data                    | in
//
// A sample word keeps busy high while the accumulator steps one power of time
// per cycle through its multiplier, so a new word is taken only once the last
// one is through. A final sample then starts the solve: the matrix is loaded,
// then each division runs on the bit-serial divider and each multiply-subtract
// on the 16-step multiplier. busy is high for the whole of that; reset leaves
// the sums clear, degree 3, threshold 1. Coefficients come out one at a time,
// constant term first.
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_unit #(
	parameter int MAX_SAMPLES = 256,
	parameter int MAX_DEGREE  = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [plsf_pkg::TIME_W-1:0]          sample_time,
	input  logic signed [plsf_pkg::VALUE_W-1:0]  sample_value,
	input  logic                                 final_sample,
	output logic                                 coeff_strobe,
	output logic [plsf_pkg::POWER_W-1:0]         coeff_power,
	output logic signed [plsf_pkg::COEF_W-1:0]   coeff_value,
	output logic                                 coeff_last,
	input  logic                                 cfg_we,
	input  logic [plsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plsf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import plsf_pkg::*;

	logic [DEGREE_W-1:0] fit_degree_q;
	logic [THR_W-1:0]    pivot_threshold_q;
	logic                final_q;
	logic                accept;
	logic                acc_busy, acc_done, acc_clear;
	logic                solve_go, solve_busy;
	logic [SUM_W-1:0]    tps [2*MAX_DEGREE+1];
	logic [SUM_W-1:0]    wvs [MAX_DEGREE+1];
	coef_t               coef;

	assign busy     = acc_busy || solve_busy;
	assign accept   = start && !busy;
	assign solve_go = acc_done && final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_degree_q      <= DEGREE_W'(3);
			pivot_threshold_q <= THR_W'(1);
			final_q           <= 1'b0;
		end else begin
			if (accept) final_q <= final_sample;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIT_DEGREE:      fit_degree_q      <= cfg_data[DEGREE_W-1:0];
					CFG_PIVOT_THRESHOLD: pivot_threshold_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	plsf_accum #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_DEGREE  (MAX_DEGREE)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.t      (sample_time),
		.y      (sample_value),
		.clear  (acc_clear),
		.busy   (acc_busy),
		.done   (acc_done),
		.tps    (tps),
		.wvs    (wvs)
	);

	plsf_solver #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (solve_go),
		.deg       (fit_degree_q),
		.thr       (pivot_threshold_q),
		.tps       (tps),
		.wvs       (wvs),
		.busy      (solve_busy),
		.acc_clear (acc_clear),
		.coef      (coef)
	);

	assign coeff_strobe = coef.strobe;
	assign coeff_power  = coef.power;
	assign coeff_value  = coef.value;
	assign coeff_last   = coef.last;

endmodule

// File: bench/polynomial_least_squares_fit_unit_checker.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_unit_checker
// Watches the sample, coefficient and config channels of the fit unit. It
// keeps its own power sums and solves the normal equations in sign-magnitude
// Q95.32 for every final sample, then compares each coefficient word in order.
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_unit_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [plsf_pkg::TIME_W-1:0]          sample_time,
	input  logic signed [plsf_pkg::VALUE_W-1:0]  sample_value,
	input  logic                                 final_sample,
	input  logic                                 coeff_strobe,
	input  logic [plsf_pkg::POWER_W-1:0]         coeff_power,
	input  logic signed [plsf_pkg::COEF_W-1:0]   coeff_value,
	input  logic                                 coeff_last,
	input  logic                                 cfg_we,
	input  logic [plsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plsf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                   fails,
	output int                                   pending
);
	import plsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPOW  = 7;
	localparam int NCOEF = 4;

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic [COEF_W-1:0]  value;
		logic               last;
	} coef_word_t;

	coef_word_t        coef_q[$];
	logic [SUM_W-1:0]  pow_sum[NPOW];
	logic [SUM_W-1:0]  wval_sum[NCOEF];
	int unsigned       n_samples;
	logic [DEGREE_W-1:0] degree;
	logic [THR_W-1:0]  threshold;

	initial begin
		fails   = 0;
		pending = 0;
	end

	function automatic wide_t sm_norm(logic neg, logic [MAG_W-1:0] mag);
		wide_t r;
		r.neg = neg && (mag != '0);
		r.mag = mag;
		return r;
	endfunction

	function automatic wide_t sm_sum(wide_t a, wide_t b);
		logic [MAG_W:0] s;
		if (a.neg == b.neg) begin
			s = {1'b0, a.mag} + {1'b0, b.mag};
			if (s[MAG_W]) return sm_norm(a.neg, '1);
			return sm_norm(a.neg, s[MAG_W-1:0]);
		end
		if (a.mag == b.mag) return '0;
		if (a.mag > b.mag) return sm_norm(a.neg, a.mag - b.mag);
		return sm_norm(b.neg, b.mag - a.mag);
	endfunction

	function automatic wide_t sm_diff(wide_t a, wide_t b);
		wide_t nb;
		nb = b;
		if (b.mag != '0) nb.neg = !b.neg;
		return sm_sum(a, nb);
	endfunction

	function automatic wide_t sm_prod(wide_t a, wide_t b);
		logic [2*MAG_W-1:0] p;
		p = {{MAG_W{1'b0}}, a.mag} * {{MAG_W{1'b0}}, b.mag};
		if (|p[2*MAG_W-1:MAG_W+32]) return sm_norm(a.neg != b.neg, '1);
		return sm_norm(a.neg != b.neg, p[MAG_W+31:32]);
	endfunction

	function automatic wide_t sm_quot(wide_t a, wide_t b);
		logic [MAG_W+31:0] num;
		logic [MAG_W+31:0] q;
		num = {a.mag, 32'b0};
		q   = num / {32'b0, b.mag};
		if (|q[MAG_W+31:MAG_W]) return sm_norm(a.neg != b.neg, '1);
		return sm_norm(a.neg != b.neg, q[MAG_W-1:0]);
	endfunction

	function automatic logic [COEF_W-1:0] sm_to_coef(wide_t a);
		logic [COEF_W-1:0] m;
		m = a.mag[COEF_W-1:0];
		if (|a.mag[MAG_W-1:COEF_W])
			return a.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (!a.neg) return m[COEF_W-1] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		if (m > 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
		return ~m + 64'd1;
	endfunction

	task automatic clear_sums();
		for (int i = 0; i < NPOW; i++) pow_sum[i] = '0;
		for (int i = 0; i < NCOEF; i++) wval_sum[i] = '0;
		n_samples = 0;
	endtask

	task automatic accumulate(logic [TIME_W-1:0] t, logic signed [VALUE_W-1:0] v);
		logic [SUM_W-1:0] pw;
		logic [SUM_W-1:0] ys;
		pw = 64'd1;
		ys = {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
		for (int i = 0; i < NPOW; i++) begin
			pow_sum[i] += pw;
			if (i < NCOEF) wval_sum[i] += pw * ys;
			pw = pw * {56'b0, t};
		end
		n_samples++;
	endtask

	// Gaussian elimination without pivoting, skipping small pivots
	task automatic solve_fit();
		wide_t mat[NCOEF][NCOEF];
		wide_t rhs[NCOEF];
		wide_t sol[NCOEF];
		wide_t piv;
		wide_t fac;
		wide_t thr;
		logic [SUM_W-1:0] m;
		coef_word_t w;
		int n;
		n   = int'(degree) + 1;
		thr = sm_norm(1'b0, {{(MAG_W-THR_W){1'b0}}, threshold});
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++)
				mat[i][j] = sm_norm(1'b0, {31'b0, pow_sum[i+j], 32'b0});
			m = wval_sum[i][SUM_W-1] ? (~wval_sum[i] + 64'd1) : wval_sum[i];
			rhs[i] = sm_norm(wval_sum[i][SUM_W-1], {43'b0, m, 20'b0});
		end
		for (int i = 0; i < n; i++) begin
			piv = mat[i][i];
			if (piv.mag == '0 || piv.mag < thr.mag) continue;
			for (int j = i; j < n; j++) mat[i][j] = sm_quot(mat[i][j], piv);
			rhs[i] = sm_quot(rhs[i], piv);
			for (int k = i + 1; k < n; k++) begin
				fac = mat[k][i];
				for (int j = i; j < n; j++)
					mat[k][j] = sm_diff(mat[k][j], sm_prod(fac, mat[i][j]));
				rhs[k] = sm_diff(rhs[k], sm_prod(fac, rhs[i]));
			end
		end
		for (int i = n - 1; i >= 0; i--) begin
			sol[i] = rhs[i];
			for (int j = i + 1; j < n; j++)
				sol[i] = sm_diff(sol[i], sm_prod(mat[i][j], sol[j]));
		end
		for (int i = 0; i < n; i++) begin
			w.power = POWER_W'(i);
			w.value = sm_to_coef(sol[i]);
			w.last  = (i == n - 1);
			coef_q.push_back(w);
		end
		clear_sums();
	endtask

	task automatic report(string what, logic [COEF_W-1:0] want, logic [COEF_W-1:0] got);
		$display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_word_t w;
		if (!arst_n) begin
			coef_q.delete();
			clear_sums();
			degree    = 2'd3;
			threshold = 33'd1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIT_DEGREE:      degree = cfg_data[DEGREE_W-1:0];
					CFG_PIVOT_THRESHOLD: threshold = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (coeff_strobe) begin
				if (coef_q.size() == 0) begin
					$display("[%0t] coefficient word with none expected", $realtime);
					fails++;
				end else begin
					w = coef_q.pop_front();
					if (coeff_power !== w.power) report("coeff_power", w.power, coeff_power);
					if (coeff_value !== w.value) report("coeff_value", w.value, coeff_value);
					if (coeff_last !== w.last) report("coeff_last", w.last, coeff_last);
				end
			end
			if (start && !busy) begin
				if (n_samples < 256) accumulate(sample_time, sample_value);
				if (final_sample) solve_fit();
			end
		end
		pending = coef_q.size();
	end

endmodule

// File: bench/polynomial_least_squares_fit_unit_tb.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_unit_tb
// Drives sample sets of many shapes through the fit unit under a series of
// degree and pivot threshold settings, with bursty input and drain pauses.
// The checker predicts and compares every coefficient word.
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_unit_tb;
	import plsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [TIME_W-1:0]          sample_time;
	logic signed [VALUE_W-1:0]  sample_value;
	logic                       final_sample;
	logic                       coeff_strobe;
	logic [POWER_W-1:0]         coeff_power;
	logic signed [COEF_W-1:0]   coeff_value;
	logic                       coeff_last;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	int                         fails;
	int                         pending;
	int                         cycles;
	int                         burst_left;

	polynomial_least_squares_fit_unit uut (.*);

	polynomial_least_squares_fit_unit_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		sample_time  = '0;
		sample_value = '0;
		final_sample = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_FIT_DEGREE;
		cfg_data     = '0;
		cycles       = 0;
		burst_left   = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic pause(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold start until the word is taken
	task automatic send_word(logic [TIME_W-1:0] t, logic [VALUE_W-1:0] v, logic f);
		logic taken;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		start        <= 1'b1;
		sample_time  <= t;
		sample_value <= v;
		final_sample <= f;
		do begin
			@(posedge clk);
			taken = !busy;
		end while (!taken);
	endtask

	// drop start and wait until every coefficient is out and the unit is idle
	task automatic drain();
		pause(1);
		while (pending != 0 || busy) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_degree(int d);
		logic [CFG_DATA_W-1:0] d33;
		d33 = CFG_DATA_W'({$urandom, $urandom});
		d33[DEGREE_W-1:0] = DEGREE_W'(d);
		write_reg(CFG_FIT_DEGREE, d33);
	endtask

	// shape: 0 full range times, 1 small times, 2 one repeated time
	task automatic random_set(int len, int shape);
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t;
		t0 = TIME_W'($urandom);
		for (int k = 0; k < len; k++) begin
			case (shape)
				0:       t = TIME_W'($urandom);
				1:       t = TIME_W'($urandom_range(0, 15));
				default: t = t0;
			endcase
			send_word(t, VALUE_W'($urandom), k == len - 1);
		end
	endtask

	initial begin
		int len;
		int shape;
		logic [THR_W-1:0] thr;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: degree 3, threshold 1
		send_word(8'd0, 24'h800000, 1'b0);
		send_word(8'd255, 24'h7FFFFF, 1'b0);
		send_word(8'd1, 24'h000000, 1'b0);
		send_word(8'd128, 24'h000001, 1'b1);
		// lone sample at time zero leaves every pivot but the first zero
		send_word(8'd0, 24'h00007B, 1'b1);
		set_degree(0);
		write_reg(CFG_PIVOT_THRESHOLD, 33'd0);
		send_word(8'd255, 24'h7FFFFF, 1'b0);
		send_word(8'd255, 24'h800000, 1'b1);
		set_degree(1);
		write_reg(CFG_PIVOT_THRESHOLD, 33'h1_0000_0000);
		send_word(8'd1, 24'h001000, 1'b0);
		send_word(8'd2, 24'h002000, 1'b0);
		send_word(8'd3, 24'hFFFFFF, 1'b1);
		// repeated time with zero threshold: zero pivots still skipped
		set_degree(2);
		write_reg(CFG_PIVOT_THRESHOLD, 33'd0);
		send_word(8'd5, 24'h123456, 1'b0);
		send_word(8'd5, 24'hABCDEF, 1'b0);
		send_word(8'd5, 24'h000400, 1'b1);
		set_degree(3);
		write_reg(CFG_PIVOT_THRESHOLD, 33'h1_FFFF_FFFF);
		send_word(8'd10, 24'h7FFFFF, 1'b0);
		send_word(8'd20, 24'h000000, 1'b0);
		send_word(8'd30, 24'h800000, 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			set_degree($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0:       thr = 33'd0;
				1:       thr = 33'd1;
				2:       thr = 33'h1_0000_0000;
				default: thr = THR_W'({$urandom, $urandom});
			endcase
			write_reg(CFG_PIVOT_THRESHOLD, thr);
			for (int s = 0; s < 3; s++) begin
				len   = $urandom_range(1, 8);
				shape = $urandom_range(0, 5);
				random_set(len, shape > 2 ? 1 : (shape == 2 ? 2 : 0));
				if ($urandom_range(0, 3) == 0) drain();
			end
		end

		drain();
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/plsf_pkg.sv
hw/rtl/plsf_accum.sv
hw/rtl/plsf_mul.sv
hw/rtl/plsf_div.sv
hw/rtl/plsf_solver.sv
hw/rtl/polynomial_least_squares_fit_unit.sv
bench/polynomial_least_squares_fit_unit_checker.sv
bench/polynomial_least_squares_fit_unit_tb.sv
